[hdl/sts_pkg.sv]
// Shared types and constants for the segment tree range sum block.
package sts_pkg;

   localparam int DATA_W  = 32;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_U_READ,
      ST_U_DELTA,
      ST_U_WALK,
      ST_U_DRAIN,
      ST_Q_WALK,
      ST_Q_DRAIN,
      ST_Q_OUT
   } state_type;

endpackage

[hdl/sts_if.sv]
// Channel interfaces: request, response and register write.
interface sts_req_if import sts_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [INDEX_W-1:0]        position;
   logic signed [DATA_W-1:0]  new_value;
   logic [INDEX_W-1:0]        range_left;
   logic [INDEX_W-1:0]        range_right;

   modport source (output valid, func, position, new_value, range_left, range_right,
                   input ready);
   modport sink (input valid, func, position, new_value, range_left, range_right,
                 output ready);
endinterface

interface sts_rsp_if import sts_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  range_sum;

   modport source (output valid, range_sum, input ready);
   modport sink (input valid, range_sum, output ready);
endinterface

interface sts_csr_if import sts_pkg::*;;
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  element_count;

   modport source (output valid, element_count, input ready);
   modport sink (input valid, element_count, output ready);
endinterface

[hdl/segment_tree_range_sum.sv]
// An update reads the old element, writes the new one, then walks the path from
// root to leaf with a read-modify-write of each node; a query visits tree nodes
// one at a time (about 4 per level) via the single read port of the node RAM.
// One request at a time; a finished response waits in an output register.
// After reset both memories are cleared to zero before the first request is taken.
module segment_tree_range_sum import sts_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int TREE_NODES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   sts_req_if.sink    req_chan,
   sts_rsp_if.source  rsp_chan,
   sts_csr_if.sink    csr_chan
);

   localparam int EL_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = EL_W + 1;
   localparam int TN_AW = $clog2(TREE_NODES);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [CNT_W-1:0]   count_eff;

   logic              elem_wr_en;
   logic [EL_W-1:0]   elem_wr_addr;
   logic [DATA_W-1:0] elem_wr_data;
   logic              elem_rd_en;
   logic [EL_W-1:0]   elem_rd_addr;
   logic [DATA_W-1:0] elem_rd_data;
   logic              node_wr_en;
   logic [TN_AW-1:0]  node_wr_addr;
   logic [DATA_W-1:0] node_wr_data;
   logic              node_rd_en;
   logic [TN_AW-1:0]  node_rd_addr;
   logic [DATA_W-1:0] node_rd_data;

   assign csr_chan.ready = 1'b1;
   assign count_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.element_count : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // count above the store size acts as the store size
   assign count_eff = (32'(count_ff) > 32'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                          : CNT_W'(count_ff);

   sts_ram #(
      .DEPTH (MAX_ELEMENTS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_en   (elem_rd_en),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   sts_ram #(
      .DEPTH (TREE_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_data)
   );

   sts_walk #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .TREE_NODES   (TREE_NODES)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .count        (count_eff),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .elem_wr_en   (elem_wr_en),
      .elem_wr_addr (elem_wr_addr),
      .elem_wr_data (elem_wr_data),
      .elem_rd_en   (elem_rd_en),
      .elem_rd_addr (elem_rd_addr),
      .elem_rd_data (elem_rd_data),
      .node_wr_en   (node_wr_en),
      .node_wr_addr (node_wr_addr),
      .node_wr_data (node_wr_data),
      .node_rd_en   (node_rd_en),
      .node_rd_addr (node_rd_addr),
      .node_rd_data (node_rd_data)
   );

endmodule

[hdl/sts_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module sts_ram import sts_pkg::*; #(
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sts_walk.sv]
// Sequencer: memory clear, point update path walk and range query tree walk.
module sts_walk import sts_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int TREE_NODES = 4096,
   localparam int EL_W = $clog2(MAX_ELEMENTS),
   localparam int CNT_W = EL_W + 1,
   localparam int TN_AW = $clog2(TREE_NODES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  count,
   sts_req_if.sink           req,
   sts_rsp_if.source         rsp,
   output logic              elem_wr_en,
   output logic [EL_W-1:0]   elem_wr_addr,
   output logic [DATA_W-1:0] elem_wr_data,
   output logic              elem_rd_en,
   output logic [EL_W-1:0]   elem_rd_addr,
   input  logic [DATA_W-1:0] elem_rd_data,
   output logic              node_wr_en,
   output logic [TN_AW-1:0]  node_wr_addr,
   output logic [DATA_W-1:0] node_wr_data,
   output logic              node_rd_en,
   output logic [TN_AW-1:0]  node_rd_addr,
   input  logic [DATA_W-1:0] node_rd_data
);

   // node indices stay below 4*n; keep one spare bit over the store size too
   localparam int NODE_W = ((EL_W + 2 > TN_AW) ? EL_W + 2 : TN_AW) + 1;
   localparam int CLR_DEPTH = (MAX_ELEMENTS > TREE_NODES) ? MAX_ELEMENTS : TREE_NODES;
   localparam int CLR_W = $clog2(CLR_DEPTH);
   localparam int STK_DEPTH = EL_W + 1;
   localparam int SI_W = $clog2(STK_DEPTH);
   localparam int SP_W = $clog2(STK_DEPTH + 1);

   state_type state_ff, state_in;

   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [EL_W-1:0]   lo_ff, lo_in;
   logic [EL_W-1:0]   hi_ff, hi_in;
   logic [EL_W-1:0]   left_ff, left_in;
   logic [EL_W-1:0]   right_ff, right_in;
   logic [EL_W-1:0]   pos_ff, pos_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              add_pend_ff, add_pend_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [TN_AW-1:0]  wr_addr_ff, wr_addr_in;
   logic [SP_W-1:0]   sp_ff, sp_in;

   logic [NODE_W-1:0] stk_node_ff [STK_DEPTH];
   logic [EL_W-1:0]   stk_lo_ff [STK_DEPTH];
   logic [EL_W-1:0]   stk_hi_ff [STK_DEPTH];
   logic              push;

   logic              accept;
   logic              upd_ok;
   logic              qry_ok;
   logic [EL_W-1:0]   right_clamp;
   logic              node_ok;
   logic              disjoint;
   logic              covered;
   logic              leaf;
   logic [EL_W:0]     mid_sum;
   logic [EL_W-1:0]   mid;
   logic [EL_W-1:0]   mid_up;
   logic [NODE_W-1:0] child_l;
   logic [NODE_W-1:0] child_r;
   logic [SI_W-1:0]   top_idx;
   logic [SI_W-1:0]   push_idx;
   logic              clr_last;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.range_sum = $signed(rsp_sum_ff);

   assign upd_ok = 32'(req.position) < 32'(count);
   assign qry_ok = (count != '0) && (req.range_left <= req.range_right)
                   && (32'(req.range_left) < 32'(count));
   assign right_clamp = (32'(req.range_right) >= 32'(count))
                        ? EL_W'(count - CNT_W'(1)) : EL_W'(req.range_right);

   assign node_ok = node_ff < NODE_W'(TREE_NODES);
   assign disjoint = (right_ff < lo_ff) || (left_ff > hi_ff);
   assign covered = (left_ff <= lo_ff) && (hi_ff <= right_ff);
   assign leaf = !(lo_ff < hi_ff);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid = mid_sum[EL_W:1];
   assign mid_up = mid + EL_W'(1);
   assign child_l = {node_ff[NODE_W-2:0], 1'b1};
   assign child_r = child_l + NODE_W'(1);
   assign top_idx = SI_W'(sp_ff - SP_W'(1));
   assign push_idx = SI_W'(sp_ff);
   assign clr_last = clr_ff == CLR_W'(CLR_DEPTH - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.func == FUNC_UPDATE) begin
                  if (upd_ok) begin
                     state_in = ST_U_READ;
                  end
               end else if (qry_ok) begin
                  state_in = ST_Q_WALK;
               end else begin
                  state_in = ST_Q_OUT;
               end
            end
         end
         ST_U_READ:  state_in = ST_U_DELTA;
         ST_U_DELTA: state_in = ST_U_WALK;
         ST_U_WALK: begin
            if (leaf) begin
               state_in = ST_U_DRAIN;
            end
         end
         ST_U_DRAIN: state_in = ST_IDLE;
         ST_Q_WALK: begin
            if ((disjoint || covered) && (sp_ff == '0)) begin
               state_in = ST_Q_DRAIN;
            end
         end
         ST_Q_DRAIN: state_in = ST_Q_OUT;
         ST_Q_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in = clr_ff;
      node_in = node_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      left_in = left_ff;
      right_in = right_ff;
      pos_in = pos_ff;
      value_in = value_ff;
      delta_in = delta_ff;
      acc_in = acc_ff;
      rsp_sum_in = rsp_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      add_pend_in = 1'b0;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      sp_in = sp_ff;
      push = 1'b0;

      elem_wr_en = 1'b0;
      elem_wr_addr = pos_ff;
      elem_wr_data = value_ff;
      elem_rd_en = 1'b0;
      elem_rd_addr = pos_ff;
      node_rd_en = 1'b0;
      node_rd_addr = TN_AW'(node_ff);

      // finish the read-modify-write of the node read last cycle
      node_wr_en = wr_pend_ff;
      node_wr_addr = wr_addr_ff;
      node_wr_data = node_rd_data + delta_ff;

      if (add_pend_ff) begin
         acc_in = acc_ff + node_rd_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            elem_wr_en = 32'(clr_ff) < 32'(MAX_ELEMENTS);
            elem_wr_addr = EL_W'(clr_ff);
            elem_wr_data = '0;
            node_wr_en = 32'(clr_ff) < 32'(TREE_NODES);
            node_wr_addr = TN_AW'(clr_ff);
            node_wr_data = '0;
         end
         ST_IDLE: begin
            if (accept) begin
               pos_in = EL_W'(req.position);
               value_in = DATA_W'(unsigned'(req.new_value));
               left_in = EL_W'(req.range_left);
               right_in = right_clamp;
               node_in = '0;
               lo_in = '0;
               hi_in = EL_W'(count - CNT_W'(1));
               acc_in = '0;
               sp_in = '0;
            end
         end
         ST_U_READ: begin
            elem_rd_en = 1'b1;
         end
         ST_U_DELTA: begin
            delta_in = value_ff - elem_rd_data;
            elem_wr_en = 1'b1;
         end
         ST_U_WALK: begin
            if (node_ok) begin
               node_rd_en = 1'b1;
               wr_pend_in = 1'b1;
               wr_addr_in = TN_AW'(node_ff);
            end
            if (!leaf) begin
               if (pos_ff <= mid) begin
                  node_in = child_l;
                  hi_in = mid;
               end else begin
                  node_in = child_r;
                  lo_in = mid_up;
               end
            end
         end
         ST_Q_WALK: begin
            if (covered && node_ok) begin
               node_rd_en = 1'b1;
               add_pend_in = 1'b1;
            end
            if (disjoint || covered) begin
               if (sp_ff != '0) begin
                  node_in = stk_node_ff[top_idx];
                  lo_in = stk_lo_ff[top_idx];
                  hi_in = stk_hi_ff[top_idx];
                  sp_in = sp_ff - SP_W'(1);
               end
            end else begin
               // descend left now, defer the right child
               push = 1'b1;
               sp_in = sp_ff + SP_W'(1);
               node_in = child_l;
               hi_in = mid;
            end
         end
         ST_Q_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in = acc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         add_pend_ff <= 1'b0;
         wr_pend_ff <= 1'b0;
         sp_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         add_pend_ff <= add_pend_in;
         wr_pend_ff <= wr_pend_in;
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      left_ff <= left_in;
      right_ff <= right_in;
      pos_ff <= pos_in;
      value_ff <= value_in;
      delta_ff <= delta_in;
      acc_ff <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
      wr_addr_ff <= wr_addr_in;
      if (push) begin
         stk_node_ff[push_idx] <= child_r;
         stk_lo_ff[push_idx] <= mid_up;
         stk_hi_ff[push_idx] <= hi_ff;
      end
   end

endmodule

[test/sts_checker.sv]
// Scoreboard for the segment tree range sum block: shadow tree, prediction and response check.
`timescale 1ns / 100ps
module sts_checker import sts_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int TREE_NODES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   sts_req_if           req_mon,
   sts_rsp_if           rsp_mon,
   sts_csr_if           csr_mon,
   output int unsigned  mismatch_count,
   output int unsigned  pending
);

   logic [DATA_W-1:0]  element_shadow [MAX_ELEMENTS];
   logic [DATA_W-1:0]  node_shadow [TREE_NODES];
   logic [COUNT_W-1:0] count_shadow;
   logic [DATA_W-1:0]  expected_sums [$];

   function automatic int unsigned covered_elements();
      return (count_shadow > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(count_shadow);
   endfunction

   function automatic void add_to_path_node(int unsigned node, logic [DATA_W-1:0] delta);
      if (node < TREE_NODES) begin
         node_shadow[node] += delta;
      end
   endfunction

   // walk root to leaf, adding the change of the element to each node passed
   function automatic void apply_point_update(int unsigned pos, logic [DATA_W-1:0] value);
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned node;
      logic [DATA_W-1:0] delta;
      n = covered_elements();
      if (pos >= n) begin
         return;
      end
      delta = value - element_shadow[pos];
      element_shadow[pos] = value;
      lo = 0;
      hi = n - 1;
      node = 0;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         add_to_path_node(node, delta);
         if (pos <= mid) begin
            node = 2 * node + 1;
            hi = mid;
         end else begin
            node = 2 * node + 2;
            lo = mid + 1;
         end
      end
      add_to_path_node(node, delta);
   endfunction

   function automatic logic [DATA_W-1:0] subtree_sum(int unsigned node, int unsigned left,
                                                     int unsigned right, int unsigned lo,
                                                     int unsigned hi);
      int unsigned mid;
      logic [DATA_W-1:0] acc;
      if (right < lo || left > hi) begin
         return '0;
      end
      if (left <= lo && hi <= right) begin
         return (node < TREE_NODES) ? node_shadow[node] : '0;
      end
      mid = (lo + hi) / 2;
      acc = subtree_sum(2 * node + 1, left, right, lo, mid);
      acc += subtree_sum(2 * node + 2, left, right, mid + 1, hi);
      return acc;
   endfunction

   function automatic logic [DATA_W-1:0] predict_range_sum(int unsigned left,
                                                           int unsigned right);
      int unsigned n;
      int unsigned last;
      n = covered_elements();
      if (n == 0 || left > right || left >= n) begin
         return '0;
      end
      last = (right >= n) ? n - 1 : right;
      return subtree_sum(0, left, last, 0, n - 1);
   endfunction

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < MAX_ELEMENTS; i++) element_shadow[i] = '0;
         for (int i = 0; i < TREE_NODES; i++) node_shadow[i] = '0;
         count_shadow = COUNT_RESET;
         expected_sums.delete();
         mismatch_count <= 0;
      end else begin
         // response first: it always belongs to an earlier request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_sums.size() == 0) begin
               $error("range_sum: no request outstanding, got %0d", $signed(rsp_mon.range_sum));
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_mon.range_sum !== want) begin
                  $error("range_sum: expected %0d, got %0d", $signed(want),
                         $signed(rsp_mon.range_sum));
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            count_shadow = csr_mon.element_count;
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_QUERY) begin
               expected_sums.push_back(predict_range_sum(32'(req_mon.range_left),
                                                         32'(req_mon.range_right)));
            end else begin
               apply_point_update(32'(req_mon.position), req_mon.new_value);
            end
         end
      end
      pending <= expected_sums.size();
   end

endmodule

[test/tb_top.sv]
// Top of the segment tree range sum regression: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top import sts_pkg::*;;

   localparam int MAX_ELEMENTS = 1024;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 32;
   localparam int LONG_HOLD    = 300;
   localparam int NUM_PHASES   = 11;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned pending;
   int unsigned idle_cycles;
   bit          req_gaps_on;
   bit          rsp_gaps_on;
   bit          hold_request;

   sts_req_if req_chan ();
   sts_rsp_if rsp_chan ();
   sts_csr_if csr_chan ();

   segment_tree_range_sum u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   sts_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // response side: random back-pressure, plus one long hold-off on demand
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_request(logic func, logic [INDEX_W-1:0] pos, logic [DATA_W-1:0] value,
                               logic [INDEX_W-1:0] left, logic [INDEX_W-1:0] right);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= func;
      req_chan.position    <= pos;
      req_chan.new_value   <= value;
      req_chan.range_left  <= left;
      req_chan.range_right <= right;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
   endtask

   // unused fields of each request carry random data
   task automatic send_update(logic [INDEX_W-1:0] pos, logic [DATA_W-1:0] value);
      send_request(FUNC_UPDATE, pos, value, INDEX_W'($urandom), INDEX_W'($urandom));
   endtask

   task automatic send_query(logic [INDEX_W-1:0] left, logic [INDEX_W-1:0] right);
      send_request(FUNC_QUERY, INDEX_W'($urandom), $urandom, left, right);
   endtask

   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // updates give no response; let the last one finish its walk
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_element_count(logic [COUNT_W-1:0] count);
      wait_until_drained();
      csr_chan.valid         <= 1'b1;
      csr_chan.element_count <= count;
      @(posedge clock);
      while (csr_chan.ready !== 1'b1) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_random_phase(logic [COUNT_W-1:0] count, int unsigned items);
      int unsigned n;
      int unsigned pick;
      logic [INDEX_W-1:0] pos;
      logic [INDEX_W-1:0] left;
      logic [INDEX_W-1:0] right;
      logic [DATA_W-1:0]  value;
      n = (int'(count) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(count);
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            pos = (n > 0 && pick < 4) ? INDEX_W'($urandom_range(0, n - 1)) : INDEX_W'($urandom);
            case ($urandom_range(0, 7))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = '0;
               3: value = '1;
               default: value = $urandom;
            endcase
            send_update(pos, value);
         end else begin
            if (n > 0 && pick < 9) begin
               left  = INDEX_W'($urandom_range(0, n - 1));
               right = INDEX_W'($urandom_range(left, n - 1));
            end else begin
               left  = INDEX_W'($urandom);
               right = INDEX_W'($urandom);
            end
            send_query(left, right);
         end
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_counts [NUM_PHASES];
      req_chan.valid         <= 1'b0;
      req_chan.func          <= FUNC_UPDATE;
      req_chan.position      <= '0;
      req_chan.new_value     <= '0;
      req_chan.range_left    <= '0;
      req_chan.range_right   <= '0;
      csr_chan.valid         <= 1'b0;
      csr_chan.element_count <= '0;
      req_gaps_on  = 1'b1;
      rsp_gaps_on  = 1'b1;
      hold_request = 1'b0;
      phase_counts = '{11'd0, 11'd1, 11'd2, 11'd1024, 11'd2047, 11'd3, 11'd1025, 11'd100,
                       11'd513, 11'd700, 11'd1024};
      wait (reset === 1'b0);
      @(posedge clock);

      // full-size tree at its reset count
      send_query(10'd0, 10'd1023);
      send_update(10'd0, 32'h7FFF_FFFF);
      send_update(10'd1023, 32'h8000_0000);
      send_update(10'd1, 32'hFFFF_FFFF);
      send_update(10'd512, 32'd1);
      send_update(10'd511, 32'd5);
      send_query(10'd0, 10'd1023);
      send_query(10'd0, 10'd0);
      send_query(10'd1023, 10'd1023);
      send_query(10'd511, 10'd512);
      send_query(10'd5, 10'd3);
      send_query(10'd0, 10'd1);
      send_update(10'd0, 32'd0);
      send_query(10'd0, 10'd2);
      wait_until_drained();

      // stall the response side long enough to back up the request side
      hold_request = 1'b1;
      run_random_phase(11'd1024, 12);

      write_element_count(11'd0);
      send_update(10'd3, 32'h1234_5678);
      send_query(10'd0, 10'd1023);
      write_element_count(11'd1);
      send_update(10'd0, 32'h0000_0042);
      send_update(10'd1, 32'h0000_0099);
      send_query(10'd0, 10'd1023);
      send_query(10'd1, 10'd1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_element_count(phase_counts[p]);
         if (p == NUM_PHASES - 1) begin
            req_gaps_on = 1'b0;
            rsp_gaps_on = 1'b0;
         end else begin
            req_gaps_on = $urandom_range(0, 3) != 0;
            rsp_gaps_on = $urandom_range(0, 3) != 0;
         end
         run_random_phase(phase_counts[p], (phase_counts[p] == 0) ? 30 : 65);
         if (p == 4) begin
            wait_until_drained();
         end
      end

      wait_until_drained();
      if (mismatch_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
